// File: design/li_chao_max_line_tree_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef LI_CHAO_MAX_LINE_TREE_MACROS_SVH
`define LI_CHAO_MAX_LINE_TREE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define LCT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("lct check failed");
// next-cycle implication checked outside reset
`define LCT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("lct check failed");
`endif

// File: design/lct_pkg.sv
// Package for the Li Chao max line tree: widths, opcodes, request and result
// payloads, sequencer states. No dependencies.
`default_nettype none
package lct_pkg;
   localparam int XBitsDefault    = 32;
   localparam int NodeCountDefault = 4096;
   localparam int SlopeW  = 24;
   localparam int InterW  = 48;
   localparam int QxW     = 32;
   localparam int ValW    = 56;
   // line value is computed wide: 24b slope * 33b x + 48b intercept
   localparam int EvalW   = 64;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                   opcode;
      logic signed [SlopeW-1:0] line_slope;
      logic signed [InterW-1:0] line_intercept;
      logic signed [QxW-1:0]    query_x;
   } req_type;

   typedef struct packed {
      logic signed [ValW-1:0] best_value;
      logic                   value_valid;
      logic                   pool_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_EVAL,
      ST_DECIDE,
      ST_ALLOC,
      ST_QEVAL,
      ST_QSTEP,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: design/lct_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface lct_if #(
   parameter type PAYLOAD_TYPE = logic
) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/lct_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module lct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/lct_eval.sv
// Shared line evaluator: registered slope * x + intercept.
// Depends on lct_pkg.
`default_nettype none
module lct_eval (
   input  wire logic                              clock,
   input  wire logic signed [lct_pkg::SlopeW-1:0] slope,
   input  wire logic signed [lct_pkg::InterW-1:0] inter,
   input  wire logic signed [32:0]                xval,
   output      logic signed [lct_pkg::EvalW-1:0]  value_ff
);
   logic signed [lct_pkg::EvalW-1:0] value_in;
   always_comb begin
      value_in = lct_pkg::EvalW'(slope) * lct_pkg::EvalW'(xval) + lct_pkg::EvalW'(inter);
   end
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

// File: design/li_chao_max_line_tree.sv
// Li Chao max line tree: one request at a time over one node RAM port and one
// shared multiplier. An insert visits each occupied node with read, wait, six
// multiplier passes and decide, the empty root with read and wait, and a new
// child takes one more write state; a query visits each node with read, wait,
// a multiplier pass when the node holds a line, and a step; at most X_BITS+1
// nodes. Each request also passes the idle and result states; results can stall. Sync reset.
`default_nettype none
module li_chao_max_line_tree #(
   parameter int X_BITS     = lct_pkg::XBitsDefault,
   parameter int NODE_COUNT = lct_pkg::NodeCountDefault
) (
   input wire logic clock,
   input wire logic reset,
   lct_if.sink      req,
   lct_if.source    rsp
);
   localparam int AW = $clog2(NODE_COUNT);
   localparam int CW = AW + 1;
   localparam int RW = lct_pkg::SlopeW + lct_pkg::InterW + 2 * AW + 1;

   // node word: has_line, left, right, slope, intercept
   typedef struct packed {
      logic                              has;
      logic [AW-1:0]                     left;
      logic [AW-1:0]                     right;
      logic signed [lct_pkg::SlopeW-1:0] slope;
      logic signed [lct_pkg::InterW-1:0] inter;
   } node_type;

   lct_pkg::state_type state_ff, state_in;
   node_type node_ff, node_in, rd_node, wr_node;
   logic [RW-1:0] rd_raw;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] free_ff, free_in;
   logic root_touched_ff, root_touched_in;
   logic signed [lct_pkg::SlopeW-1:0] m_ff, m_in;
   logic signed [lct_pkg::InterW-1:0] b_ff, b_in;
   logic signed [32:0] s_ff, s_in, e_ff, e_in, x_ff, x_in, mid;
   logic [2:0] step_ff, step_in;
   logic qry_ff, qry_in;
   logic signed [lct_pkg::EvalW-1:0] best_ff, best_in;
   // kept / new line values at s, e and the kept one at mid
   logic signed [lct_pkg::EvalW-1:0] ks_ff, ks_in, ns_ff, ns_in;
   logic signed [lct_pkg::EvalW-1:0] ke_ff, ke_in, ne_ff, ne_in, km_ff, km_in;
   logic found_ff, found_in, full_ff, full_in;
   logic wr_en;
   logic signed [lct_pkg::SlopeW-1:0] ev_m;
   logic signed [lct_pkg::InterW-1:0] ev_b;
   logic signed [32:0] ev_x;
   logic signed [lct_pkg::EvalW-1:0] ev_v;

   // sum of s and e fits in 34 bits; arithmetic shift gives floor
   logic signed [33:0] sum;
   assign sum = 34'(s_ff) + 34'(e_ff);
   assign mid = 33'(sum >>> 1);

   lct_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_ram (
      .clock, .wr_en, .wr_addr(addr_ff), .wr_data(wr_node),
      .rd_addr(addr_ff), .rd_data(rd_raw)
   );

   lct_eval u_eval (.clock, .slope(ev_m), .inter(ev_b), .xval(ev_x), .value_ff(ev_v));

   // the root lives in RAM but reads empty with no children until first write;
   // every other node is written whole when it is allocated
   always_comb begin
      rd_node = rd_raw;
      if (addr_ff == '0 && !root_touched_ff) begin
         rd_node.has   = 1'b0;
         rd_node.left  = '0;
         rd_node.right = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lct_pkg::ST_IDLE;
         free_ff         <= CW'(1);
         root_touched_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         free_ff         <= free_in;
         root_touched_ff <= root_touched_in;
      end
      node_ff <= node_in; addr_ff <= addr_in; m_ff <= m_in; b_ff <= b_in;
      s_ff <= s_in; e_ff <= e_in; x_ff <= x_in; step_ff <= step_in;
      qry_ff <= qry_in; best_ff <= best_in; found_ff <= found_in; full_ff <= full_in;
      ks_ff <= ks_in; ns_ff <= ns_in; ke_ff <= ke_in; ne_ff <= ne_in; km_ff <= km_in;
   end

   always_comb begin
      logic signed [33:0] half;
      logic swap, go_right;
      logic signed [lct_pkg::EvalW-1:0] lo_e, hi_e, lo_m, hi_m;
      logic signed [lct_pkg::SlopeW-1:0] lm, hm;
      logic signed [lct_pkg::InterW-1:0] lb, hb;
      logic [AW-1:0] child;
      half = 34'sd1 <<< (X_BITS - 1);
      state_in = state_ff; node_in = node_ff; addr_in = addr_ff;
      free_in = free_ff; root_touched_in = root_touched_ff;
      m_in = m_ff; b_in = b_ff; s_in = s_ff; e_in = e_ff; x_in = x_ff;
      step_in = step_ff; qry_in = qry_ff; best_in = best_ff;
      found_in = found_ff; full_in = full_ff;
      ks_in = ks_ff; ns_in = ns_ff; ke_in = ke_ff; ne_in = ne_ff; km_in = km_ff;
      wr_en = 1'b0; wr_node = node_ff;
      ev_m = node_ff.slope; ev_b = node_ff.inter; ev_x = s_ff;
      req.ready = 1'b0; rsp.valid = 1'b0;
      rsp.data = '0;
      // the kept line counts as upper only when strictly above at s
      swap = ks_ff > ns_ff;
      lo_e = swap ? ne_ff : ke_ff;
      hi_e = swap ? ke_ff : ne_ff;
      lo_m = swap ? ev_v : km_ff;
      hi_m = swap ? km_ff : ev_v;
      hm = swap ? node_ff.slope : m_ff;
      hb = swap ? node_ff.inter : b_ff;
      lm = swap ? m_ff : node_ff.slope;
      lb = swap ? b_ff : node_ff.inter;
      child = '0; go_right = 1'b0;
      case (state_ff)
         lct_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               addr_in = '0;
               m_in = req.data.line_slope;
               b_in = req.data.line_intercept;
               // wrap x into the domain
               x_in = 33'(signed'(req.data.query_x[X_BITS-1:0]));
               s_in = 33'(-half);
               e_in = 33'(half - 34'sd1);
               qry_in = (req.data.opcode == lct_pkg::OP_QUERY);
               found_in = 1'b0; full_in = 1'b0; best_in = '0;
               state_in = lct_pkg::ST_READ;
            end
         end
         lct_pkg::ST_READ: state_in = lct_pkg::ST_WAIT;
         lct_pkg::ST_WAIT: begin
            node_in = rd_node;
            if (qry_ff) begin
               state_in = rd_node.has ? lct_pkg::ST_QEVAL : lct_pkg::ST_QSTEP;
            end else if (!rd_node.has) begin
               // empty node: take the line and stop
               wr_node = rd_node;
               wr_node.has = 1'b1; wr_node.slope = m_ff; wr_node.inter = b_ff;
               wr_en = 1'b1;
               if (addr_ff == '0) root_touched_in = 1'b1;
               state_in = lct_pkg::ST_DONE;
            end else begin
               step_in = '0;
               state_in = lct_pkg::ST_EVAL;
            end
         end
         // six multiplier passes: kept/new at s, e, mid; each result is captured in the next step
         lct_pkg::ST_EVAL: begin
            ev_m = step_ff[0] ? m_ff : node_ff.slope;
            ev_b = step_ff[0] ? b_ff : node_ff.inter;
            ev_x = (step_ff < 3'd2) ? s_ff : (step_ff < 3'd4) ? e_ff : mid;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: ks_in = ev_v;
               3'd2: ns_in = ev_v;
               3'd3: ke_in = ev_v;
               3'd4: ne_in = ev_v;
               3'd5: begin
                  km_in = ev_v;
                  state_in = lct_pkg::ST_DECIDE;
               end
               default: ;
            endcase
         end
         // ev_v holds the new line at mid
         lct_pkg::ST_DECIDE: begin
            wr_en = 1'b1;
            if (lo_e <= hi_e) begin
               // upper line wins the whole segment
               wr_node.slope = hm; wr_node.inter = hb;
               state_in = lct_pkg::ST_DONE;
            end else begin
               go_right = (lo_m <= hi_m);
               if (go_right) begin
                  wr_node.slope = hm; wr_node.inter = hb;
                  child = node_ff.right;
                  m_in = lm; b_in = lb;
                  s_in = mid + 33'sd1;
               end else begin
                  wr_node.slope = lm; wr_node.inter = lb;
                  child = node_ff.left;
                  m_in = hm; b_in = hb;
                  e_in = mid;
               end
               if (child != '0) begin
                  addr_in = child;
                  state_in = lct_pkg::ST_READ;
               end else if (free_ff >= CW'(NODE_COUNT)) begin
                  // pool exhausted: keep the winner, drop the loser
                  full_in = 1'b1;
                  state_in = lct_pkg::ST_DONE;
               end else begin
                  child = AW'(free_ff);
                  free_in = free_ff + CW'(1);
                  if (go_right) wr_node.right = child;
                  else wr_node.left = child;
                  addr_in = child;
                  state_in = lct_pkg::ST_ALLOC;
               end
            end
         end
         // a fresh child takes the carried line with no children
         lct_pkg::ST_ALLOC: begin
            wr_node.has = 1'b1; wr_node.left = '0; wr_node.right = '0;
            wr_node.slope = m_ff; wr_node.inter = b_ff;
            wr_en = 1'b1;
            state_in = lct_pkg::ST_DONE;
         end
         lct_pkg::ST_QEVAL: begin
            ev_m = node_ff.slope; ev_b = node_ff.inter; ev_x = x_ff;
            state_in = lct_pkg::ST_QSTEP;
         end
         lct_pkg::ST_QSTEP: begin
            // a node with a line came through ST_QEVAL, so ev_v is its value at x
            if (node_ff.has) begin
               if (!found_ff || ev_v > best_ff) best_in = ev_v;
               found_in = 1'b1;
            end
            if (x_ff <= mid) begin
               child = node_ff.left; e_in = mid;
            end else begin
               child = node_ff.right; s_in = mid + 33'sd1;
            end
            addr_in = child;
            state_in = (child == '0) ? lct_pkg::ST_DONE : lct_pkg::ST_READ;
         end
         lct_pkg::ST_DONE: begin
            rsp.valid = 1'b1;
            rsp.data.best_value  = found_ff ? lct_pkg::ValW'(best_ff) : '0;
            rsp.data.value_valid = found_ff;
            rsp.data.pool_full   = full_ff;
            if (rsp.ready) state_in = lct_pkg::ST_IDLE;
         end
         default: state_in = lct_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: design/lct_checker.sv
// Port-level checker for the Li Chao max line tree, bound to the top level.
// Depends on the macros header.
`default_nettype none
`include "li_chao_max_line_tree_macros.svh"
module lct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_value_valid,
   input wire logic        rsp_pool_full
);
   // a result never carries both a value and a full flag
   `LCT_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !(rsp_value_valid && rsp_pool_full))
   // no new request while a result is pending
   `LCT_ASSERT_IMP(a_busy, clock, reset, rsp_valid, !req_ready)
   // accepting a request leaves the block busy next cycle
   `LCT_ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, !req_ready)
   // a stalled result stays offered
   `LCT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind li_chao_max_line_tree lct_checker u_lct_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_value_valid(rsp.data.value_valid), .rsp_pool_full(rsp.data.pool_full)
);
`default_nettype wire

// File: tb/sv/li_chao_max_line_tree_tb.sv
`timescale 1ns / 100ps
// Testbench for li_chao_max_line_tree: random and directed inserts and queries,
// checked against an in-bench line envelope tree. Depends on lct_pkg and lct_if.
module li_chao_max_line_tree_tb;
   localparam int XBits     = lct_pkg::XBitsDefault;
   localparam int NodeCount = lct_pkg::NodeCountDefault;
   localparam int TailItems = 300;   // no idling over the last requests
   localparam int DrainCycles = 400; // idle wait after the last response
   // tangent lines y = k*x - A*k*k all touch the envelope
   localparam int TangentShift = 14;

   logic clock;
   logic reset;

   lct_if #(.PAYLOAD_TYPE(lct_pkg::req_type)) req_ch ();
   lct_if #(.PAYLOAD_TYPE(lct_pkg::rsp_type)) rsp_ch ();

   li_chao_max_line_tree #(.X_BITS(XBits), .NODE_COUNT(NodeCount)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // ---------------------------------------------------------------------------
   // Envelope tree mirror: own copy of the node pool
   // ---------------------------------------------------------------------------
   longint env_slope[NodeCount];
   longint env_icpt[NodeCount];
   bit     env_used[NodeCount];
   int     env_left[NodeCount];
   int     env_right[NodeCount];
   int     env_next;

   lct_pkg::req_type pending_reqs[$];
   lct_pkg::rsp_type expected_rsps[$];
   int        mismatches;
   int        accepted_reqs;
   int        total_reqs;
   bit        quiet_tail;

   function automatic longint line_at(longint m, longint b, longint x);
      return m * x + b;
   endfunction

   // take a fresh child node, 0 when the pool is exhausted
   function automatic int alloc_node();
      int n;
      if (env_next >= NodeCount) return 0;
      n = env_next;
      env_next++;
      env_used[n]  = 0;
      env_left[n]  = 0;
      env_right[n] = 0;
      return n;
   endfunction

   // insert a line; return 1 when the descent was cut short by a full pool
   function automatic bit add_line(longint m, longint b);
      longint s, e, mid, lm, lb, hm, hb, t;
      int node, child;
      s = -(longint'(1) <<< (XBits - 1));
      e = (longint'(1) <<< (XBits - 1)) - 1;
      node = 0;
      forever begin
         if (!env_used[node]) begin
            env_slope[node] = m;
            env_icpt[node]  = b;
            env_used[node]  = 1;
            return 0;
         end
         lm = env_slope[node]; lb = env_icpt[node];
         hm = m; hb = b;
         // kept line strictly above at s becomes the upper one
         if (line_at(lm, lb, s) > line_at(hm, hb, s)) begin
            t = lm; lm = hm; hm = t;
            t = lb; lb = hb; hb = t;
         end
         if (line_at(lm, lb, e) <= line_at(hm, hb, e)) begin
            env_slope[node] = hm;
            env_icpt[node]  = hb;
            return 0;
         end
         mid = (s + e) >>> 1;
         if (line_at(lm, lb, mid) <= line_at(hm, hb, mid)) begin
            env_slope[node] = hm;
            env_icpt[node]  = hb;
            child = env_right[node];
            if (child == 0) begin
               child = alloc_node();
               if (child == 0) return 1;
               env_right[node] = child;
            end
            m = lm; b = lb;
            s = mid + 1;
         end else begin
            env_slope[node] = lm;
            env_icpt[node]  = lb;
            child = env_left[node];
            if (child == 0) begin
               child = alloc_node();
               if (child == 0) return 1;
               env_left[node] = child;
            end
            m = hm; b = hb;
            e = mid;
         end
         node = child;
      end
   endfunction

   // walk the path of x and keep the best line value met
   function automatic bit best_at(longint x, output longint best);
      longint s, e, mid, v;
      int node;
      bit found;
      s = -(longint'(1) <<< (XBits - 1));
      e = (longint'(1) <<< (XBits - 1)) - 1;
      node = 0;
      found = 0;
      best = 0;
      for (int depth = 0; depth <= XBits + 1; depth++) begin
         if (env_used[node]) begin
            v = line_at(env_slope[node], env_icpt[node], x);
            if (!found || v > best) best = v;
            found = 1;
         end
         mid = (s + e) >>> 1;
         if (x <= mid) begin
            node = env_left[node];
            e = mid;
         end else begin
            node = env_right[node];
            s = mid + 1;
         end
         if (node == 0) break;
      end
      return found;
   endfunction

   function automatic lct_pkg::rsp_type predict_rsp(lct_pkg::req_type r);
      lct_pkg::rsp_type p;
      longint best;
      p = '0;
      if (r.opcode == lct_pkg::OP_INSERT) begin
         p.pool_full = add_line(longint'(r.line_slope), longint'(r.line_intercept));
      end else if (best_at(longint'(r.query_x), best)) begin
         p.best_value  = best[lct_pkg::ValW-1:0];
         p.value_valid = 1'b1;
      end
      return p;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic lct_pkg::req_type noise_item(lct_pkg::op_type op);
      lct_pkg::req_type r;
      r.opcode         = op;
      r.line_slope     = lct_pkg::SlopeW'($urandom);
      r.line_intercept = lct_pkg::InterW'({$urandom, $urandom});
      r.query_x        = $urandom;
      return r;
   endfunction

   // line tangent to the parabola at slope k, so it always lands on the envelope
   function automatic lct_pkg::req_type tangent_insert();
      lct_pkg::req_type r;
      longint k;
      r = noise_item(lct_pkg::OP_INSERT);
      k = longint'($urandom_range(131070)) - 65535;
      r.line_slope     = lct_pkg::SlopeW'(k);
      r.line_intercept = lct_pkg::InterW'(-((k * k) <<< TangentShift));
      return r;
   endfunction

   // query near a tangent point, or anywhere
   function automatic lct_pkg::req_type probe_query();
      lct_pkg::req_type r;
      longint k;
      r = noise_item(lct_pkg::OP_QUERY);
      if ($urandom_range(1)) begin
         k = longint'($urandom_range(131070)) - 65535;
         r.query_x = lct_pkg::QxW'((k <<< (TangentShift + 1))
                                   + longint'($urandom_range(64)) - 32);
      end
      return r;
   endfunction

   function automatic lct_pkg::req_type make_item(longint m, longint b, longint x,
                                                  lct_pkg::op_type op);
      lct_pkg::req_type r;
      r.opcode = op;
      r.line_slope = lct_pkg::SlopeW'(m);
      r.line_intercept = lct_pkg::InterW'(b);
      r.query_x = lct_pkg::QxW'(x);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, reset, stimulus
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      int pick;
      reset = 1'b1;
      mismatches = 0;
      accepted_reqs = 0;
      quiet_tail = 0;
      env_used[0] = 0; env_left[0] = 0; env_right[0] = 0;
      env_next = 1;

      // directed: empty tree, extreme lines, ties, extreme coordinates
      pending_reqs.push_back(make_item(0, 0, 0, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, -(longint'(1) <<< 31), lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(0, 0, 5, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, 0, lct_pkg::OP_INSERT));     // exact tie
      pending_reqs.push_back(make_item(8388607, 140737488355327, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(-8388608, -140737488355328, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(-8388608, 140737488355327, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(1, 0, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(-1, 0, 0, lct_pkg::OP_INSERT));    // crosses at zero
      pending_reqs.push_back(make_item(0, 0, -(longint'(1) <<< 31), lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, (longint'(1) <<< 31) - 1, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, 0, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, -1, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(0, 0, 1, lct_pkg::OP_QUERY));
      pending_reqs.push_back(make_item(3, -7, 0, lct_pkg::OP_INSERT));
      pending_reqs.push_back(make_item(3, -7, 0, lct_pkg::OP_INSERT));    // same line again
      pending_reqs.push_back(make_item(0, 0, 1234567, lct_pkg::OP_QUERY));

      // random mix of envelope lines, arbitrary lines and probes
      repeat (1750) begin
         pick = $urandom_range(99);
         if (pick < 40) pending_reqs.push_back(probe_query());
         else if (pick < 75) pending_reqs.push_back(tangent_insert());
         else pending_reqs.push_back(noise_item(lct_pkg::op_type'(pick[0])));
      end
      repeat (40) pending_reqs.push_back(probe_query());
      total_reqs = pending_reqs.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_reqs == total_reqs && expected_rsps.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         report_mismatch("responses missing", expected_rsps.size(), 0);
      end
      if (mismatches == 0) begin
         $display("** li_chao_max_line_tree: PASSED **");
      end else begin
         $display("** li_chao_max_line_tree: FAILED **");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("[%0t] timeout", $time);
      $display("** li_chao_max_line_tree: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Request driver: hold each request until accepted, idle in short bursts
   // ---------------------------------------------------------------------------
   int req_gap;

   always @(posedge clock) begin
      logic             nxt_valid;
      lct_pkg::req_type nxt_data;
      nxt_valid = req_ch.valid;
      nxt_data  = req_ch.data;
      if (reset) begin
         nxt_valid = 1'b0;
         nxt_data  = '0;
         req_gap   = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         quiet_tail = (pending_reqs.size() < TailItems);
         nxt_valid  = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_reqs.size() != 0) begin
            nxt_data  = pending_reqs.pop_front();
            nxt_valid = 1'b1;
            if (!quiet_tail && $urandom_range(7) == 0) req_gap = $urandom_range(1, 5);
         end
      end
      req_ch.valid <= nxt_valid;
      req_ch.data  <= nxt_data;
   end

   // predict at acceptance so the mirror sees requests in the block's order
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_rsps.push_back(predict_rsp(req_ch.data));
         accepted_reqs++;
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: random stalls, compare against the oldest prediction
   // ---------------------------------------------------------------------------
   int rsp_stall;

   always @(posedge clock) begin
      logic             nxt_ready;
      lct_pkg::rsp_type want;
      nxt_ready = 1'b1;
      if (reset) begin
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.data.best_value !== want.best_value)
                  report_mismatch("best_value", rsp_ch.data.best_value, want.best_value);
               if (rsp_ch.data.value_valid !== want.value_valid)
                  report_mismatch("value_valid", rsp_ch.data.value_valid, want.value_valid);
               if (rsp_ch.data.pool_full !== want.pool_full)
                  report_mismatch("pool_full", rsp_ch.data.pool_full, want.pool_full);
            end
         end
         // drop ready for a short burst now and then
         if (rsp_stall > 0) begin
            rsp_stall--;
            nxt_ready = 1'b0;
         end else if (!quiet_tail && $urandom_range(9) == 0) begin
            rsp_stall = $urandom_range(0, 4);
            nxt_ready = 1'b0;
         end
      end
      rsp_ch.ready <= nxt_ready;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end
endmodule
